// ===== src/tcf_pkg.sv =====
`default_nettype none

package tcf_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int TILES_W     = (SCREEN_WIDTH + 7) / 8;
    localparam int TILES_H     = (SCREEN_HEIGHT + 7) / 8;
    localparam int BYTES_TOTAL = TILES_W * SCREEN_HEIGHT;
    localparam int TILES_TOTAL = TILES_W * TILES_H;

    localparam int BITS_AW = (BYTES_TOTAL > 1) ? $clog2(BYTES_TOTAL) : 1;
    localparam int TILE_AW = (TILES_TOTAL > 1) ? $clog2(TILES_TOTAL) : 1;
    localparam int TX_W    = (TILES_W > 1) ? $clog2(TILES_W) : 1;
    localparam int TY_W    = (TILES_H > 1) ? $clog2(TILES_H) : 1;
    localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
    localparam int COL_W   = $clog2(SCREEN_WIDTH);

    localparam int COORD_W   = 11;
    localparam int COLOR_W   = 16;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int TILE_DW   = 2 * COLOR_W;

    localparam logic [OP_W-1:0] OP_DRAW   = 3'd0;
    localparam logic [OP_W-1:0] OP_INVERT = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 16'h00ff;
    localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

    localparam logic [7:0] PIX_MSB_MASK = 8'h80;

    typedef struct packed {
        logic [OP_W-1:0]    kind;
        logic               on;
        logic [BITS_AW-1:0] byte_addr;
        logic [TILE_AW-1:0] tile_addr;
        logic [2:0]         bit_sel;
        logic [TX_W-1:0]    tx0;
        logic [TX_W-1:0]    tx1;
        logic [TY_W-1:0]    ty0;
        logic [TY_W-1:0]    ty1;
        logic [ROW_W-1:0]   top;
        logic [ROW_W-1:0]   bottom;
        logic               pending;
    } t_cmd;

    function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== src/tcf_ram.sv =====
`default_nettype none

module tcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/tcf_front.sv =====
`default_nettype none

module tcf_front (
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic [tcf_pkg::OP_W-1:0]           i_operation,
    input  wire logic signed [tcf_pkg::COORD_W-1:0] i_x_first,
    input  wire logic signed [tcf_pkg::COORD_W-1:0] i_y_first,
    input  wire logic signed [tcf_pkg::COORD_W-1:0] i_x_second,
    input  wire logic signed [tcf_pkg::COORD_W-1:0] i_y_second,
    input  wire logic                               i_pixel_on,
    input  wire logic                               i_init_done,
    input  wire logic                               i_full,
    output      logic                               o_push,
    output      tcf_pkg::t_cmd                      o_cmd
);

    localparam logic signed [tcf_pkg::COORD_W-1:0] X_LAST =
        tcf_pkg::COORD_W'(tcf_pkg::SCREEN_WIDTH - 1);
    localparam logic signed [tcf_pkg::COORD_W-1:0] Y_LAST =
        tcf_pkg::COORD_W'(tcf_pkg::SCREEN_HEIGHT - 1);
    localparam logic signed [tcf_pkg::COORD_W-1:0] ZERO_S = '0;

    function automatic logic signed [tcf_pkg::COORD_W-1:0] clamp_s(
        input logic signed [tcf_pkg::COORD_W-1:0] v,
        input logic signed [tcf_pkg::COORD_W-1:0] hi
    );
        return (v < ZERO_S) ? ZERO_S : ((v > hi) ? hi : v);
    endfunction

    logic                                draw_ok;
    logic                                rect_off;
    logic                                keep;
    logic [tcf_pkg::COL_W-1:0]           px;
    logic [tcf_pkg::ROW_W-1:0]           py;
    logic [tcf_pkg::TX_W-1:0]            ptx;
    logic signed [tcf_pkg::COORD_W-1:0]  rx0, rx1, ry0, ry1;
    logic signed [tcf_pkg::COORD_W-1:0]  cx0, cx1, cy0, cy1;
    logic signed [tcf_pkg::COORD_W-1:0]  uy0, uy1;

    always_comb begin
        draw_ok = (i_x_first >= ZERO_S) && (i_x_first <= X_LAST) &&
                  (i_y_first >= ZERO_S) && (i_y_first <= Y_LAST);
        px  = tcf_pkg::COL_W'($unsigned(i_x_first));
        py  = tcf_pkg::ROW_W'($unsigned(i_y_first));
        ptx = tcf_pkg::TX_W'(px >> 3);

        // corners ordered per axis, then clipped
        rx0 = (i_x_first > i_x_second) ? i_x_second : i_x_first;
        rx1 = (i_x_first > i_x_second) ? i_x_first  : i_x_second;
        ry0 = (i_y_first > i_y_second) ? i_y_second : i_y_first;
        ry1 = (i_y_first > i_y_second) ? i_y_first  : i_y_second;
        rect_off = (rx1 < ZERO_S) || (rx0 > X_LAST) || (ry1 < ZERO_S) || (ry0 > Y_LAST);
        cx0 = clamp_s(rx0, X_LAST);
        cx1 = clamp_s(rx1, X_LAST);
        cy0 = clamp_s(ry0, Y_LAST);
        cy1 = clamp_s(ry1, Y_LAST);

        uy0 = (i_y_first < ZERO_S) ? ZERO_S : i_y_first;
        uy1 = ((i_y_second > Y_LAST) || (i_y_second < ZERO_S)) ? Y_LAST : i_y_second;

        o_cmd.kind      = i_operation;
        o_cmd.on        = i_pixel_on;
        o_cmd.byte_addr = tcf_pkg::BITS_AW'(int'(py) * tcf_pkg::TILES_W + int'(ptx));
        o_cmd.tile_addr = tcf_pkg::TILE_AW'(int'(py >> 3) * tcf_pkg::TILES_W + int'(ptx));
        o_cmd.bit_sel   = px[2:0];
        o_cmd.tx0       = tcf_pkg::TX_W'($unsigned(cx0) >> 3);
        o_cmd.tx1       = tcf_pkg::TX_W'($unsigned(cx1) >> 3);
        o_cmd.ty0       = tcf_pkg::TY_W'($unsigned(cy0) >> 3);
        o_cmd.ty1       = tcf_pkg::TY_W'($unsigned(cy1) >> 3);
        o_cmd.top       = tcf_pkg::ROW_W'($unsigned(uy0));
        o_cmd.bottom    = tcf_pkg::ROW_W'($unsigned(uy1));
        o_cmd.pending   = (uy0 <= uy1);

        unique case (i_operation) inside
            tcf_pkg::OP_DRAW:   keep = draw_ok;
            tcf_pkg::OP_INVERT: keep = !rect_off;
            tcf_pkg::OP_CLEAR,
            tcf_pkg::OP_UPDATE,
            tcf_pkg::OP_SCAN:   keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign o_in_ready = i_init_done && !i_full;
    assign o_push     = i_in_valid && o_in_ready && keep;

endmodule

`default_nettype wire

// ===== src/tcf_queue.sv =====
`default_nettype none

module tcf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tcf_pkg::t_cmd i_data,
    output      logic          o_full,
    input  wire logic          i_pop,
    output      tcf_pkg::t_cmd o_data,
    output      logic          o_empty
);

    tcf_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== src/tcf_back.sv =====
`default_nettype none

module tcf_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [tcf_pkg::COLOR_W-1:0]   i_fg_color,
    input  wire logic [tcf_pkg::COLOR_W-1:0]   i_bg_color,
    input  wire tcf_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_empty,
    output      logic                          o_pop,
    output      logic                          o_init_done,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic [tcf_pkg::COLOR_W-1:0]   o_pixel_color,
    output      logic                          o_group_last,
    output      logic                          o_window_done,
    output      logic                          o_nothing_pending
);

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DRAW_RD = 4'd2;
    localparam logic [3:0] S_DRAW_WR = 4'd3;
    localparam logic [3:0] S_INV_RD  = 4'd4;
    localparam logic [3:0] S_INV_WR  = 4'd5;
    localparam logic [3:0] S_SCAN_RD = 4'd6;
    localparam logic [3:0] S_SCAN_LD = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;
    localparam logic [3:0] S_NONE    = 4'd9;

    localparam logic [tcf_pkg::BITS_AW-1:0] SWEEP_LAST = tcf_pkg::BITS_AW'(tcf_pkg::BYTES_TOTAL - 1);
    localparam logic [tcf_pkg::TX_W-1:0]    GRP_LAST   = tcf_pkg::TX_W'(tcf_pkg::TILES_W - 1);

    logic [3:0]                  r_state, n_state;
    tcf_pkg::t_cmd               r_cmd;
    logic                        r_init_done;
    logic [tcf_pkg::BITS_AW-1:0] r_cnt;
    logic [tcf_pkg::COLOR_W-1:0] r_sweep_fg, r_sweep_bg;
    logic [tcf_pkg::TX_W-1:0]    r_tx;
    logic [tcf_pkg::TY_W-1:0]    r_ty;
    logic [tcf_pkg::TILE_AW-1:0] r_row_base;
    logic [tcf_pkg::ROW_W-1:0]   r_scan_row;
    logic [tcf_pkg::ROW_W-1:0]   r_win_bottom;
    logic [tcf_pkg::TX_W-1:0]    r_scan_group;
    logic                        r_pending;
    logic [7:0]                  r_bits;
    logic [tcf_pkg::COLOR_W-1:0] r_f, r_b;
    logic                        r_done;
    logic [2:0]                  r_k;
    logic                        r_out_valid;
    logic [tcf_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_last, r_out_done, r_out_none;

    logic                        out_free;
    logic                        out_load;
    logic                        grp_end;
    logic [tcf_pkg::TILE_AW-1:0] inv_addr;
    logic [tcf_pkg::BITS_AW-1:0] scan_bits_addr;
    logic [tcf_pkg::TILE_AW-1:0] scan_tile_addr;
    logic [7:0]                  draw_mask;

    logic                        bits_we;
    logic [tcf_pkg::BITS_AW-1:0] bits_waddr, bits_raddr;
    logic [7:0]                  bits_wdata, bits_rdata;
    logic                        tile_we;
    logic [tcf_pkg::TILE_AW-1:0] tile_waddr, tile_raddr;
    logic [tcf_pkg::TILE_DW-1:0] tile_wdata, tile_rdata;

    tcf_ram #(.WIDTH(8), .DEPTH(tcf_pkg::BYTES_TOTAL)) u_bits_ram (
        .i_clk  (i_clk),
        .i_we   (bits_we),
        .i_waddr(bits_waddr),
        .i_wdata(bits_wdata),
        .i_raddr(bits_raddr),
        .o_rdata(bits_rdata)
    );

    // tile word: fg in the upper half, bg in the lower
    tcf_ram #(.WIDTH(tcf_pkg::TILE_DW), .DEPTH(tcf_pkg::TILES_TOTAL)) u_tile_ram (
        .i_clk  (i_clk),
        .i_we   (tile_we),
        .i_waddr(tile_waddr),
        .i_wdata(tile_wdata),
        .i_raddr(tile_raddr),
        .o_rdata(tile_rdata)
    );

    always_comb begin
        out_free       = !r_out_valid || i_out_ready;
        out_load       = out_free && ((r_state == S_EMIT) || (r_state == S_NONE));
        grp_end        = (r_scan_group == GRP_LAST);
        inv_addr       = r_row_base + tcf_pkg::TILE_AW'(r_tx);
        scan_bits_addr = tcf_pkg::BITS_AW'(int'(r_scan_row) * tcf_pkg::TILES_W
                                           + int'(r_scan_group));
        scan_tile_addr = tcf_pkg::TILE_AW'(int'(r_scan_row >> 3) * tcf_pkg::TILES_W
                                           + int'(r_scan_group));
        draw_mask      = tcf_pkg::PIX_MSB_MASK >> r_cmd.bit_sel;

        bits_raddr = (r_state == S_DRAW_RD) ? r_cmd.byte_addr : scan_bits_addr;
        tile_raddr = (r_state == S_INV_RD) ? inv_addr : scan_tile_addr;

        bits_we    = 1'b0;
        bits_waddr = r_cmd.byte_addr;
        bits_wdata = r_cmd.on ? (bits_rdata | draw_mask) : (bits_rdata & ~draw_mask);
        tile_we    = 1'b0;
        tile_waddr = r_cmd.tile_addr;
        tile_wdata = {i_fg_color, i_bg_color};

        unique case (r_state)
            S_SWEEP: begin
                bits_we    = 1'b1;
                bits_waddr = r_cnt;
                bits_wdata = '0;
                tile_we    = (int'(r_cnt) < tcf_pkg::TILES_TOTAL);
                tile_waddr = tcf_pkg::TILE_AW'(r_cnt);
                tile_wdata = {r_sweep_fg, r_sweep_bg};
            end
            S_DRAW_WR: begin
                bits_we = 1'b1;
                tile_we = 1'b1;
            end
            S_INV_WR: begin
                tile_we    = 1'b1;
                tile_waddr = inv_addr;
                tile_wdata = {tile_rdata[tcf_pkg::COLOR_W-1:0],
                              tile_rdata[tcf_pkg::TILE_DW-1:tcf_pkg::COLOR_W]};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                if (r_cnt == SWEEP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        tcf_pkg::OP_DRAW:   n_state = S_DRAW_RD;
                        tcf_pkg::OP_INVERT: n_state = S_INV_RD;
                        tcf_pkg::OP_CLEAR:  n_state = S_SWEEP;
                        tcf_pkg::OP_SCAN:   n_state = r_pending ? S_SCAN_RD : S_NONE;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_DRAW_RD: n_state = S_DRAW_WR;
            S_DRAW_WR: n_state = S_IDLE;
            S_INV_RD:  n_state = S_INV_WR;
            S_INV_WR: begin
                if (r_tx == r_cmd.tx1 && r_ty == r_cmd.ty1) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_INV_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_LD;
            S_SCAN_LD: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free && r_k == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_NONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_init_done  <= 1'b0;
            r_cnt        <= '0;
            r_sweep_fg   <= '0;
            r_sweep_bg   <= '0;
            r_scan_row   <= '0;
            r_win_bottom <= '0;
            r_scan_group <= '0;
            r_pending    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SWEEP_LAST) begin
                        r_init_done <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd      <= i_cmd;
                        r_tx       <= i_cmd.tx0;
                        r_ty       <= i_cmd.ty0;
                        r_row_base <= tcf_pkg::TILE_AW'(int'(i_cmd.ty0) * tcf_pkg::TILES_W);
                        if (i_cmd.kind == tcf_pkg::OP_CLEAR) begin
                            r_cnt        <= '0;
                            r_sweep_fg   <= i_fg_color;
                            r_sweep_bg   <= i_bg_color;
                            r_scan_row   <= '0;
                            r_win_bottom <= tcf_pkg::ROW_W'(tcf_pkg::SCREEN_HEIGHT - 1);
                            r_scan_group <= '0;
                            r_pending    <= 1'b1;
                        end
                        if (i_cmd.kind == tcf_pkg::OP_UPDATE) begin
                            r_scan_row   <= i_cmd.top;
                            r_win_bottom <= i_cmd.bottom;
                            r_scan_group <= '0;
                            r_pending    <= i_cmd.pending;
                        end
                    end
                end
                S_INV_WR: begin
                    if (r_tx == r_cmd.tx1) begin
                        r_tx       <= r_cmd.tx0;
                        r_ty       <= r_ty + 1'b1;
                        r_row_base <= r_row_base + tcf_pkg::TILE_AW'(tcf_pkg::TILES_W);
                    end else begin
                        r_tx <= r_tx + 1'b1;
                    end
                end
                S_SCAN_LD: begin
                    r_bits <= bits_rdata;
                    r_f    <= tcf_pkg::swap_bytes(tile_rdata[tcf_pkg::TILE_DW-1:tcf_pkg::COLOR_W]);
                    r_b    <= tcf_pkg::swap_bytes(tile_rdata[tcf_pkg::COLOR_W-1:0]);
                    r_done <= grp_end && (r_scan_row >= r_win_bottom);
                    r_k    <= '0;
                    if (grp_end && (r_scan_row >= r_win_bottom)) begin
                        r_pending <= 1'b0;
                    end else if (grp_end) begin
                        r_scan_group <= '0;
                        r_scan_row   <= r_scan_row + 1'b1;
                    end else begin
                        r_scan_group <= r_scan_group + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_color <= r_bits[3'd7 - r_k] ? r_f : r_b;
                        r_out_last  <= (r_k == 3'd7);
                        r_out_done  <= (r_k == 3'd7) && r_done;
                        r_out_none  <= 1'b0;
                        r_k         <= r_k + 1'b1;
                    end
                end
                S_NONE: begin
                    if (out_free) begin
                        r_out_color <= '0;
                        r_out_last  <= 1'b0;
                        r_out_done  <= 1'b0;
                        r_out_none  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_init_done       = r_init_done;
    assign o_out_valid       = r_out_valid;
    assign o_pixel_color     = r_out_color;
    assign o_group_last      = r_out_last;
    assign o_window_done     = r_out_done;
    assign o_nothing_pending = r_out_none;

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("window_done without group_last");

    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_none |-> !r_out_last && !r_out_done && r_out_color == '0)
        else $error("idle result carries pixel fields");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_scan_row <= r_win_bottom && r_scan_group <= GRP_LAST)
        else $error("scan position outside window");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE && r_init_done)
        else $error("command taken while engine busy");

endmodule

`default_nettype wire

// ===== src/tile_color_framebuffer_top.sv =====
// Tile-colour framebuffer, 1 bit per pixel with fg/bg colours per 8x8 tile.
// Input channel (i_in_valid/o_in_ready) takes operations: draw pixel, invert
// rectangle, clear, request update, scan group. A front end clips and decodes
// each transaction into a two-entry command queue; the engine behind it runs
// commands one at a time against the pixel RAM and the tile-colour RAM.
// Output channel (o_out_valid/i_out_ready) carries pixel colours from an output
// register. A scan gives 8 transactions, one per cycle when the receiver is
// ready, the first loaded after the engine's read and load states; an idle scan
// gives one result with o_nothing_pending set. Draw reads then writes one pixel
// byte and writes its tile's colours, invert reads and writes each tile touched,
// update sets the scan window, clear zeroes every pixel byte (TILES_W *
// SCREEN_HEIGHT, 9600 for 320x240) via the single pixel RAM write port.
// After reset the engine sweeps both RAMs to zero; o_in_ready is low until
// that is done, config writes are taken throughout. When the receiver
// stalls, the output register holds, the engine waits, then the queue fills
// and o_in_ready drops.
`default_nettype none

module tile_color_framebuffer_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_ready,
    input  wire logic [tcf_pkg::OP_W-1:0]             i_operation,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   i_x_first,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   i_y_first,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   i_x_second,
    input  wire logic signed [tcf_pkg::COORD_W-1:0]   i_y_second,
    input  wire logic                                 i_pixel_on,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_ready,
    output      logic [tcf_pkg::COLOR_W-1:0]          o_pixel_color,
    output      logic                                 o_group_last,
    output      logic                                 o_window_done,
    output      logic                                 o_nothing_pending,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [tcf_pkg::COLOR_W-1:0]          i_cfg_data
);

    logic [tcf_pkg::COLOR_W-1:0] r_fg_color;
    logic [tcf_pkg::COLOR_W-1:0] r_bg_color;

    tcf_pkg::t_cmd push_cmd, head_cmd;
    logic          push, full, pop, empty, init_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= tcf_pkg::FG_RESET;
            r_bg_color <= tcf_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcf_pkg::REG_FG: r_fg_color <= i_cfg_data;
                tcf_pkg::REG_BG: r_bg_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcf_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_operation(i_operation),
        .i_x_first  (i_x_first),
        .i_y_first  (i_y_first),
        .i_x_second (i_x_second),
        .i_y_second (i_y_second),
        .i_pixel_on (i_pixel_on),
        .i_init_done(init_done),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tcf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_data (head_cmd),
        .o_empty(empty)
    );

    tcf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fg_color       (r_fg_color),
        .i_bg_color       (r_bg_color),
        .i_cmd            (head_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_init_done      (init_done),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pixel_color    (o_pixel_color),
        .o_group_last     (o_group_last),
        .o_window_done    (o_window_done),
        .o_nothing_pending(o_nothing_pending)
    );

endmodule

`default_nettype wire

// ===== bench/tcf_checker.sv =====
module tcf_checker
    import tcf_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_ready,
    input  wire logic [OP_W-1:0]            i_operation,
    input  wire logic signed [COORD_W-1:0]  i_x_first,
    input  wire logic signed [COORD_W-1:0]  i_y_first,
    input  wire logic signed [COORD_W-1:0]  i_x_second,
    input  wire logic signed [COORD_W-1:0]  i_y_second,
    input  wire logic                       i_pixel_on,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_ready,
    input  wire logic [COLOR_W-1:0]         i_pixel_color,
    input  wire logic                       i_group_last,
    input  wire logic                       i_window_done,
    input  wire logic                       i_nothing_pending,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [COLOR_W-1:0]         i_cfg_data,
    output int                              o_pending,
    output int                              o_failures,
    output int                              o_checked,
    output int                              o_windows
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
        logic               idle;
    } t_pixel;

    logic [7:0]         pixel_mem   [BYTES_TOTAL];
    logic [COLOR_W-1:0] tile_fg_mem [TILES_TOTAL];
    logic [COLOR_W-1:0] tile_bg_mem [TILES_TOTAL];
    logic [COLOR_W-1:0] cur_fg, cur_bg;
    int                 win_bottom, scan_row, scan_grp;
    bit                 window_armed;
    t_pixel             pixels_due[$];
    int                 failures = 0;
    int                 checked = 0;
    int                 windows = 0;

    initial begin
        o_pending  = 0;
        o_failures = 0;
        o_checked  = 0;
        o_windows  = 0;
    end

    task automatic flag(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        failures++;
    endtask

    function automatic int fit(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void arm_window(input int top, input int bottom);
        if (top < 0)
            top = 0;
        if (bottom > SCREEN_HEIGHT - 1 || bottom < 0)
            bottom = SCREEN_HEIGHT - 1;
        win_bottom   = bottom;
        scan_row     = top;
        scan_grp     = 0;
        window_armed = (top <= bottom);
    endfunction

    function automatic void wipe_state();
        cur_fg = FG_RESET;
        cur_bg = BG_RESET;
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
        foreach (tile_fg_mem[i]) begin
            tile_fg_mem[i] = '0;
            tile_bg_mem[i] = '0;
        end
        win_bottom   = 0;
        scan_row     = 0;
        scan_grp     = 0;
        window_armed = 1'b0;
        pixels_due.delete();
    endfunction

    function automatic void plot(input int x, input int y, input logic on);
        int         bi, ti;
        logic [7:0] mask;
        if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
            return;
        bi   = y * TILES_W + x / 8;
        ti   = (y / 8) * TILES_W + x / 8;
        mask = PIX_MSB_MASK >> (x % 8);
        if (on)
            pixel_mem[bi] = pixel_mem[bi] | mask;
        else
            pixel_mem[bi] = pixel_mem[bi] & ~mask;
        tile_fg_mem[ti] = cur_fg;
        tile_bg_mem[ti] = cur_bg;
    endfunction

    function automatic void swap_tiles(input int x0, input int x1, input int y0, input int y1);
        int                 t;
        logic [COLOR_W-1:0] c;
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
        end
        if (y0 > y1) begin
            t = y0; y0 = y1; y1 = t;
        end
        if (x1 < 0 || x0 > SCREEN_WIDTH - 1 || y1 < 0 || y0 > SCREEN_HEIGHT - 1)
            return;
        x0 = fit(x0, 0, SCREEN_WIDTH - 1) / 8;
        x1 = fit(x1, 0, SCREEN_WIDTH - 1) / 8;
        y0 = fit(y0, 0, SCREEN_HEIGHT - 1) / 8;
        y1 = fit(y1, 0, SCREEN_HEIGHT - 1) / 8;
        for (int ty = y0; ty <= y1; ty++) begin
            for (int tx = x0; tx <= x1; tx++) begin
                t = ty * TILES_W + tx;
                c = tile_fg_mem[t];
                tile_fg_mem[t] = tile_bg_mem[t];
                tile_bg_mem[t] = c;
            end
        end
    endfunction

    function automatic void wipe_screen();
        foreach (pixel_mem[i])
            pixel_mem[i] = '0;
        foreach (tile_fg_mem[i]) begin
            tile_fg_mem[i] = cur_fg;
            tile_bg_mem[i] = cur_bg;
        end
        arm_window(0, SCREEN_HEIGHT - 1);
    endfunction

    // one idle result, or the 8 colours of the next group in the window
    function automatic void scan_group_colors();
        int                 row, grp, ti;
        logic [7:0]         bits;
        logic [COLOR_W-1:0] c, f, b;
        bit                 done;
        t_pixel             p;
        if (!window_armed) begin
            p = '{color: '0, last: 1'b0, done: 1'b0, idle: 1'b1};
            pixels_due.push_back(p);
            return;
        end
        row  = fit(scan_row, 0, SCREEN_HEIGHT - 1);
        grp  = fit(scan_grp, 0, TILES_W - 1);
        bits = pixel_mem[row * TILES_W + grp];
        ti   = (row / 8) * TILES_W + grp;
        c    = tile_fg_mem[ti];
        f    = {c[7:0], c[15:8]};
        c    = tile_bg_mem[ti];
        b    = {c[7:0], c[15:8]};
        done = (grp == TILES_W - 1) && (row >= win_bottom);
        for (int k = 0; k < 8; k++) begin
            p.color = bits[7 - k] ? f : b;
            p.last  = (k == 7);
            p.done  = (k == 7) && done;
            p.idle  = 1'b0;
            pixels_due.push_back(p);
        end
        if (done) begin
            window_armed = 1'b0;
        end else if (grp == TILES_W - 1) begin
            scan_grp = 0;
            scan_row = row + 1;
        end else begin
            scan_grp = grp + 1;
        end
    endfunction

    task automatic take_operation();
        int xa, ya, xb, yb;
        xa = i_x_first;
        ya = i_y_first;
        xb = i_x_second;
        yb = i_y_second;
        case (i_operation)
            OP_DRAW:   plot(xa, ya, i_pixel_on);
            OP_INVERT: swap_tiles(xa, xb, ya, yb);
            OP_CLEAR:  wipe_screen();
            OP_UPDATE: arm_window(ya, yb);
            OP_SCAN:   scan_group_colors();
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_pixel seen, want;
        if (!i_rst_n) begin
            wipe_state();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FG)
                    cur_fg = i_cfg_data;
                else if (i_cfg_index == REG_BG)
                    cur_bg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                take_operation();
            if (i_out_valid && i_out_ready) begin
                seen = '{color: i_pixel_color, last: i_group_last,
                         done: i_window_done, idle: i_nothing_pending};
                if (pixels_due.size() == 0) begin
                    flag($sformatf("unexpected result, colour %h", seen.color));
                end else begin
                    want = pixels_due.pop_front();
                    if (seen.color !== want.color)
                        flag($sformatf("result %0d pixel_color %h, expected %h",
                                       checked, seen.color, want.color));
                    if (seen.last !== want.last)
                        flag($sformatf("result %0d group_last %b, expected %b",
                                       checked, seen.last, want.last));
                    if (seen.done !== want.done)
                        flag($sformatf("result %0d window_done %b, expected %b",
                                       checked, seen.done, want.done));
                    if (seen.idle !== want.idle)
                        flag($sformatf("result %0d nothing_pending %b, expected %b",
                                       checked, seen.idle, want.idle));
                    if (want.done)
                        windows++;
                end
                checked++;
            end
        end
        o_pending  <= pixels_due.size();
        o_failures <= failures;
        o_checked  <= checked;
        o_windows  <= windows;
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcf_pkg::*;

    // worst case is roughly reset sweep + a few clears + big inverts + stalled scans;
    // the cap leaves a wide margin
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = BYTES_TOTAL + 256;   // a clear may still be running
    localparam int HOLD_AFTER    = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_OPS     = 50;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [OP_W-1:0]            operation;
    logic signed [COORD_W-1:0]  x_first, y_first, x_second, y_second;
    logic                       pixel_on;
    logic                       out_valid;
    logic                       out_ready;
    logic [COLOR_W-1:0]         pixel_color;
    logic                       group_last, window_done, nothing_pending;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COLOR_W-1:0]         cfg_data;

    int pending, failures, checked, windows;
    int cycles       = 0;
    int accepted_ops = 0;
    int calm_items   = 0;
    bit quiet        = 1'b0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    tile_color_framebuffer_top DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_operation       (operation),
        .i_x_first         (x_first),
        .i_y_first         (y_first),
        .i_x_second        (x_second),
        .i_y_second        (y_second),
        .i_pixel_on        (pixel_on),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_pixel_color     (pixel_color),
        .o_group_last      (group_last),
        .o_window_done     (window_done),
        .o_nothing_pending (nothing_pending),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    tcf_checker watch (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_operation       (operation),
        .i_x_first         (x_first),
        .i_y_first         (y_first),
        .i_x_second        (x_second),
        .i_y_second        (y_second),
        .i_pixel_on        (pixel_on),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_pixel_color     (pixel_color),
        .i_group_last      (group_last),
        .i_window_done     (window_done),
        .i_nothing_pending (nothing_pending),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_failures        (failures),
        .o_checked         (checked),
        .o_windows         (windows)
    );

    // receiver: random stalls, calm stretches, and one long hold-off to back the block up
    initial begin : receiver
        int calm_cycles;
        bit held_off;
        calm_cycles = 0;
        held_off    = 1'b0;
        out_ready   = 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && !quiet && checked >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!quiet && calm_cycles == 0 && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            if (calm_cycles > 0)
                calm_cycles--;
            else if ($urandom_range(0, 60) == 0)
                calm_cycles = $urandom_range(30, 150);
            out_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout: %0d cycles, %0d results still outstanding", cycles, pending);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic int rnd_coord();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    // mostly on screen, now and then just past either edge
    function automatic int pick_x();
        case ($urandom_range(0, 9))
            0:       return -int'($urandom_range(1, 8));
            1:       return SCREEN_WIDTH - 1 + int'($urandom_range(0, 8));
            default: return $urandom_range(0, SCREEN_WIDTH - 1);
        endcase
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input int xa, input int ya,
                        input int xb, input int yb, input bit on);
        operation <= op;
        x_first   <= COORD_W'(xa);
        y_first   <= COORD_W'(ya);
        x_second  <= COORD_W'(xb);
        y_second  <= COORD_W'(yb);
        pixel_on  <= on;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (op <= OP_SCAN)
            accepted_ops++;
        if (calm_items > 0)
            calm_items--;
        else if ($urandom_range(0, 25) == 0)
            calm_items = $urandom_range(10, 40);
        if (!quiet && calm_items == 0 && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // draw into a row, maybe flip some tiles, point the window at it and scan
    task automatic row_sequence();
        int row, span, bottom, n_scan;
        case ($urandom_range(0, 7))
            0:       row = SCREEN_HEIGHT - 1;
            1:       row = 8 * $urandom_range(0, TILES_H - 1) + 7;
            default: row = $urandom_range(0, SCREEN_HEIGHT - 1);
        endcase
        span = ($urandom_range(0, 7) == 0) ? 1 : 0;
        repeat ($urandom_range(0, 5))
            send(OP_DRAW, pick_x(), row + int'($urandom_range(0, span)), rnd_coord(),
                 rnd_coord(), $urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
            send(OP_INVERT, pick_x(), row, pick_x() + int'($urandom_range(0, 24)) - 12,
                 row + int'($urandom_range(0, 16)) - 8, $urandom_range(0, 1));
        bottom = row + span;
        if ($urandom_range(0, 9) == 0)
            bottom = -int'($urandom_range(1, 1024));     // negative bottom means last row
        send(OP_UPDATE, rnd_coord(), row, rnd_coord(), bottom, $urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0)
            n_scan = TILES_W * (span + 1) + $urandom_range(0, 2);
        else
            n_scan = $urandom_range(1, 12);
        repeat (n_scan)
            send(OP_SCAN, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 $urandom_range(0, 1));
    endtask

    task automatic noise_item();
        logic [OP_W-1:0] op;
        op = OP_W'($urandom_range(0, 7));
        if (op == OP_CLEAR && $urandom_range(0, 7) != 0)
            op = OP_SCAN;
        send(op, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 1));
    endtask

    task automatic run_phase(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        int start;
        in_valid <= 1'b0;
        settle();
        write_reg(REG_FG, fg);
        write_reg(REG_BG, bg);
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                  COLOR_W'($urandom));
        start = accepted_ops;
        if ($urandom_range(0, 2) != 0)
            send(OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 $urandom_range(0, 1));
        while (accepted_ops - start < PHASE_OPS) begin
            if ($urandom_range(0, 9) < 7)
                row_sequence();
            else
                noise_item();
        end
    endtask

    initial begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_SCAN;
        x_first   = '0;
        y_first   = '0;
        x_second  = '0;
        y_second  = '0;
        pixel_on  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FG;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset colours
        send(OP_SCAN, 0, 0, 0, 0, 0);                       // nothing pending yet
        send(OP_DRAW, 0, 0, 0, 0, 1);
        send(OP_DRAW, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1);
        send(OP_DRAW, 7, 0, 0, 0, 1);
        send(OP_DRAW, 7, 0, 0, 0, 0);                       // set then clear the same bit
        send(OP_DRAW, -1, 5, 0, 0, 1);
        send(OP_DRAW, SCREEN_WIDTH, 0, 0, 0, 1);
        send(OP_DRAW, 3, SCREEN_HEIGHT, 0, 0, 1);
        send(OP_DRAW, -1024, -1024, 1023, 1023, 1);
        send(OP_DRAW, 1023, 1023, -1024, -1024, 1);
        for (int c = OP_SCAN + 1; c < (1 << OP_W); c++)
            send(OP_W'(c), -1, -1, -1, -1, 1);
        send(OP_INVERT, 15, 9, 0, 0, 0);                    // corners given reversed
        send(OP_INVERT, SCREEN_WIDTH, 0, SCREEN_WIDTH + 100, 10, 0);
        send(OP_INVERT, -1024, -1024, 1023, 1023, 0);
        send(OP_UPDATE, 0, 100, 0, 50, 0);                  // top below bottom
        send(OP_SCAN, 0, 0, 0, 0, 0);
        send(OP_UPDATE, 0, -5, 0, -1, 0);
        send(OP_SCAN, 0, 0, 0, 0, 0);
        send(OP_SCAN, 0, 0, 0, 0, 0);
        send(OP_UPDATE, 0, SCREEN_HEIGHT - 1, 0, 1023, 0);
        send(OP_SCAN, 0, 0, 0, 0, 0);
        send(OP_CLEAR, 0, 0, 0, 0, 0);
        send(OP_SCAN, 0, 0, 0, 0, 0);

        run_phase(16'hffff, 16'h0000);
        run_phase(16'h0000, 16'hffff);
        run_phase(COLOR_W'($urandom), COLOR_W'($urandom));
        quiet = 1'b1;
        run_phase(COLOR_W'($urandom), COLOR_W'($urandom));
        in_valid <= 1'b0;
        settle();

        $display("covered %0d operations, %0d pixel results checked, %0d windows scanned out",
                 accepted_ops, checked, windows);
        $display("four colour settings incl. both extremes, one long output hold-off, %0d errors",
                 failures);
        if (failures == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
